>>> design/tlps_pkg.sv
package tlps_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned WidthW     = 13;
  localparam int unsigned RowW       = 12;
  localparam int unsigned SumW       = 20;
  localparam int unsigned HeightW    = 13;
  localparam int unsigned GapW       = 5;
  localparam int unsigned WsumW      = 15;
  localparam int unsigned RecipW     = 13;
  localparam int unsigned GreyRecip  = 5243;
  localparam int unsigned GreyShift  = 19;
  localparam int unsigned DivW       = 24;
  localparam int unsigned DivCntW    = 5;

  typedef enum logic [1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_THRESH,
    CFG_GAP
  } cfg_idx_e;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic acc;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic row_end;
    logic counted;
  } sts_t;

endpackage

>>> design/text_line_projection_segmenter_core.sv
// Text line segmenter by horizontal projection profile. Each request is one RGB pixel in
// raster order; every request yields one result with the grey value of the inverted pixel,
// and the last pixel of a counted row also carries the row value and, when a line closes,
// its top and bottom rows. A pixel steps through load, multiply, accumulate and finish;
// the last pixel of a counted row also runs the 24-step radix-2 divider for sum*10/width.
// A pending result is held in the output register while the next request is taken.
module text_line_projection_segmenter_core import tlps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [WidthW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              start_of_image_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        grey_o,
  output logic              row_done_o,
  output logic [7:0]        row_value_o,
  output logic              line_found_o,
  output logic [RowW-1:0]   line_top_o,
  output logic [RowW-1:0]   line_bottom_o,
  output logic [7:0]        line_index_o
);

  cmd_t cmd;
  sts_t sts;

  tlps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlps_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start_of_image_i (start_of_image_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .grey_o           (grey_o),
    .row_done_o       (row_done_o),
    .row_value_o      (row_value_o),
    .line_found_o     (line_found_o),
    .line_top_o       (line_top_o),
    .line_bottom_o    (line_bottom_o),
    .line_index_o     (line_index_o)
  );

endmodule

>>> design/tlps_ctrl.sv
module tlps_ctrl import tlps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DIV,
    S_FIN
  } state_e;

  state_e               state_q;
  logic [DivCntW-1:0]   cnt_q;
  logic                 out_valid_q;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.acc      = (state_q == S_ACC);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.load_out = (state_q == S_FIN) && out_free;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (sts_i.counted && sts_i.row_end) begin
            state_q <= S_DIV;
            cnt_q   <= DivCntW'(DivW - 1);
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/tlps_dp.sv
module tlps_dp import tlps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [WidthW-1:0] cfg_data_i,
  input  logic              start_of_image_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [7:0]        grey_o,
  output logic              row_done_o,
  output logic [7:0]        row_value_o,
  output logic              line_found_o,
  output logic [RowW-1:0]   line_top_o,
  output logic [RowW-1:0]   line_bottom_o,
  output logic [7:0]        line_index_o
);

  localparam logic [SumW-1:0]    SumMax    = '1;
  localparam logic [HeightW-1:0] HeightMax = '1;

  // configuration
  logic [WidthW-1:0] cfg_width_q, cfg_height_q;
  logic [7:0]        cfg_thresh_q;
  logic [3:0]        cfg_gap_q;

  // pixel
  logic              sof_q;
  logic [7:0]        r_q, g_q, b_q;
  logic [WsumW-1:0]  wsum_q;
  logic [7:0]        grey_q;

  // image state
  logic [SumW-1:0]    row_sum_q;
  logic [WidthW-1:0]  col_q;
  logic [WidthW-1:0]  row_cnt_q;
  logic               in_line_q;
  logic [RowW-1:0]    top_q;
  logic [HeightW-1:0] height_q;
  logic [GapW-1:0]    gap_q;
  logic [7:0]         lines_q;

  // row end and divider
  logic               row_end_q;
  logic [RowW-1:0]    row_idx_q;
  logic [DivW-1:0]    quot_q;
  logic [WidthW-1:0]  rem_q;

  // result
  logic [7:0]         out_grey_q, out_value_q, out_index_q;
  logic               out_done_q, out_found_q;
  logic [RowW-1:0]    out_top_q, out_bottom_q;

  logic [WidthW-1:0]        w_eff;
  logic [WsumW-1:0]         wsum;
  logic [WsumW+RecipW-1:0]  grey_prod;
  logic [7:0]               grey;
  logic [SumW:0]            sum_ext;
  logic [SumW-1:0]          sum_sat;
  logic [WidthW-1:0]        col_inc;
  logic                     counted;
  logic                     row_end;
  logic [DivW-1:0]          dividend;
  logic [WidthW:0]          rem_sh;
  logic [WidthW:0]          rem_sub;
  logic                     rem_ge;
  logic [7:0]               value;
  logic                     ink;
  logic [HeightW-1:0]       h_inc;
  logic                     gap_lt;
  logic                     tall;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (cfg_width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = cfg_width_q;
    end
  end

  assign wsum = WsumW'(r_q) * WsumW'(30) + WsumW'(g_q) * WsumW'(59)
              + WsumW'(b_q) * WsumW'(11);

  // divide by 100 through reciprocal
  assign grey_prod = (WsumW+RecipW)'(wsum_q) * (WsumW+RecipW)'(GreyRecip);
  assign grey      = grey_prod[GreyShift +: 8];

  assign sum_ext  = {1'b0, row_sum_q} + (SumW+1)'(grey);
  assign sum_sat  = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
  assign col_inc  = col_q + 1'b1;
  assign counted  = row_cnt_q < cfg_height_q;
  assign row_end  = col_inc >= w_eff;
  assign dividend = DivW'({sum_sat, 3'b000}) + DivW'({sum_sat, 1'b0});

  assign sts_o.row_end = row_end;
  assign sts_o.counted = counted;

  assign rem_sh  = {rem_q, quot_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, w_eff};
  assign rem_ge  = rem_sh >= {1'b0, w_eff};

  assign value = !row_end_q ? 8'd0 :
                 (|quot_q[DivW-1:8]) ? 8'hFF : quot_q[7:0];
  assign ink    = value > cfg_thresh_q;
  assign h_inc  = (height_q == HeightMax) ? height_q : height_q + 1'b1;
  assign gap_lt = gap_q < GapW'(cfg_gap_q);
  assign tall   = height_q > HeightW'(cfg_gap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthW'(640);
      cfg_height_q <= WidthW'(480);
      cfg_thresh_q <= 8'd8;
      cfg_gap_q    <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_HEIGHT: cfg_height_q <= cfg_data_i;
        CFG_THRESH: cfg_thresh_q <= cfg_data_i[7:0];
        CFG_GAP:    cfg_gap_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sof_q <= start_of_image_i;
      r_q   <= ~red_i;
      g_q   <= ~green_i;
      b_q   <= ~blue_i;
    end
    if (cmd_i.mul) wsum_q <= wsum;
    if (cmd_i.acc) begin
      grey_q    <= grey;
      row_end_q <= counted && row_end;
      row_idx_q <= row_cnt_q[RowW-1:0];
      quot_q    <= dividend;
      rem_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? rem_sub[WidthW-1:0] : rem_sh[WidthW-1:0];
      quot_q <= {quot_q[DivW-2:0], rem_ge};
    end
    if (cmd_i.load_out) begin
      out_grey_q   <= grey_q;
      out_done_q   <= row_end_q;
      out_value_q  <= value;
      out_found_q  <= 1'b0;
      out_top_q    <= '0;
      out_bottom_q <= '0;
      out_index_q  <= '0;
      if (row_end_q && in_line_q && !ink && !gap_lt && tall) begin
        out_found_q  <= 1'b1;
        out_top_q    <= top_q;
        out_bottom_q <= row_idx_q;
        out_index_q  <= lines_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
      col_q     <= '0;
      row_cnt_q <= '0;
      in_line_q <= 1'b0;
      top_q     <= '0;
      height_q  <= '0;
      gap_q     <= '0;
      lines_q   <= '0;
    end else if (cmd_i.mul) begin
      if (sof_q) begin
        row_sum_q <= '0;
        col_q     <= '0;
        row_cnt_q <= '0;
        in_line_q <= 1'b0;
        top_q     <= '0;
        height_q  <= '0;
        gap_q     <= '0;
        lines_q   <= '0;
      end
    end else if (cmd_i.acc) begin
      if (counted) begin
        if (row_end) begin
          row_sum_q <= '0;
          col_q     <= '0;
          row_cnt_q <= row_cnt_q + 1'b1;
        end else begin
          row_sum_q <= sum_sat;
          col_q     <= col_inc;
        end
      end
    end else if (cmd_i.load_out && row_end_q) begin
      if (ink && !in_line_q) begin
        in_line_q <= 1'b1;
        height_q  <= h_inc;
        top_q     <= row_idx_q;
      end else if (in_line_q && ink) begin
        height_q <= h_inc;
        gap_q    <= '0;
      end else if (in_line_q && gap_lt) begin
        height_q <= h_inc;
        gap_q    <= gap_q + 1'b1;
      end else begin
        if (in_line_q && tall && lines_q != 8'hFF) lines_q <= lines_q + 1'b1;
        height_q  <= '0;
        in_line_q <= 1'b0;
        top_q     <= '0;
      end
    end
  end

  assign grey_o        = out_grey_q;
  assign row_done_o    = out_done_q;
  assign row_value_o   = out_value_q;
  assign line_found_o  = out_found_q;
  assign line_top_o    = out_top_q;
  assign line_bottom_o = out_bottom_q;
  assign line_index_o  = out_index_q;

endmodule

>>> tb/text_line_projection_segmenter_core_tb.sv
`timescale 1ns / 100ps

module text_line_projection_segmenter_core_tb;
  import tlps_pkg::*;

  localparam int unsigned CycleLimit   = 8000000;
  localparam int unsigned RandomPixels = 450;
  localparam int unsigned WidePixels   = 40;

  typedef struct packed {
    logic [7:0]      grey;
    logic            row_done;
    logic [7:0]      row_value;
    logic            line_found;
    logic [RowW-1:0] line_top;
    logic [RowW-1:0] line_bottom;
    logic [7:0]      line_index;
  } px_result_t;

  typedef enum logic [1:0] {
    ROW_BLANK,
    ROW_INK,
    ROW_FAINT,
    ROW_NOISE
  } row_kind_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_index_i;
  logic [WidthW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              start_of_image_i;
  logic [7:0]        red_i;
  logic [7:0]        green_i;
  logic [7:0]        blue_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [7:0]        grey_o;
  logic              row_done_o;
  logic [7:0]        row_value_o;
  logic              line_found_o;
  logic [RowW-1:0]   line_top_o;
  logic [RowW-1:0]   line_bottom_o;
  logic [7:0]        line_index_o;

  // segmenter configuration and detector state
  logic [WidthW-1:0]  img_width;
  logic [WidthW-1:0]  img_height;
  logic [7:0]         ink_thresh;
  logic [3:0]         gap_limit;
  logic [SumW-1:0]    row_sum;
  logic [WidthW-1:0]  col_cnt;
  logic [WidthW-1:0]  row_cnt;
  logic               line_open;
  logic [RowW-1:0]    line_start;
  logic [HeightW-1:0] line_height;
  logic [GapW-1:0]    gap_cnt;
  logic [7:0]         line_cnt;

  px_result_t  pixel_results_q[$];
  px_result_t  want_px;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned stall_left;
  logic        tx_idle;
  logic        rx_idle;

  text_line_projection_segmenter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_of_image_i (start_of_image_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .grey_o           (grey_o),
    .row_done_o       (row_done_o),
    .row_value_o      (row_value_o),
    .line_found_o     (line_found_o),
    .line_top_o       (line_top_o),
    .line_bottom_o    (line_bottom_o),
    .line_index_o     (line_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_detector();
    row_sum     = '0;
    col_cnt     = '0;
    row_cnt     = '0;
    line_open   = 1'b0;
    line_start  = '0;
    line_height = '0;
    gap_cnt     = '0;
    line_cnt    = '0;
  endfunction

  function automatic px_result_t segment_pixel(logic sof, logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b);
    px_result_t         res;
    int unsigned        grey_full;
    int unsigned        eff_w;
    int unsigned        acc;
    int unsigned        ratio;
    logic               ink;
    logic [HeightW-1:0] grown;
    res = '0;
    if (sof) clear_detector();
    grey_full = (30 * (255 - 32'(r)) + 59 * (255 - 32'(g)) + 11 * (255 - 32'(b))) / 100;
    res.grey = grey_full[7:0];
    eff_w = (img_width == 0) ? 1 : (img_width > MaxWidth) ? MaxWidth : 32'(img_width);
    if (row_cnt < img_height) begin
      acc = 32'(row_sum) + grey_full;
      row_sum = (acc > 32'hFFFFF) ? '1 : acc[SumW-1:0];
      col_cnt = col_cnt + 1'b1;
      if (32'(col_cnt) >= eff_w) begin
        ratio = (32'(row_sum) * 10) / eff_w;
        if (ratio > 255) ratio = 255;
        res.row_done  = 1'b1;
        res.row_value = ratio[7:0];
        ink   = ratio > 32'(ink_thresh);
        grown = (line_height == '1) ? line_height : line_height + 1'b1;
        if (ink && !line_open) begin
          line_open   = 1'b1;
          line_height = grown;
          line_start  = row_cnt[RowW-1:0];
        end else if (line_open && ink) begin
          line_height = grown;
          gap_cnt     = '0;
        end else if (line_open && gap_cnt < gap_limit) begin
          line_height = grown;
          gap_cnt     = gap_cnt + 1'b1;
        end else begin
          if (line_open && line_height > gap_limit) begin
            res.line_found  = 1'b1;
            res.line_top    = line_start;
            res.line_bottom = row_cnt[RowW-1:0];
            res.line_index  = line_cnt;
            if (line_cnt != 8'hFF) line_cnt = line_cnt + 1'b1;
          end
          line_height = '0;
          line_open   = 1'b0;
          line_start  = '0;
        end
        row_sum = '0;
        col_cnt = '0;
        row_cnt = row_cnt + 1'b1;
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] make_pixel(row_kind_e kind);
    logic [23:0] px;
    for (int c = 0; c < 3; c++) begin
      case (kind)
        ROW_BLANK: px[c*8 +: 8] = 8'hFF;
        ROW_INK:   px[c*8 +: 8] = 8'($urandom_range(0, 60));
        ROW_FAINT: px[c*8 +: 8] = 8'(255 - $urandom_range(0, 40));
        default:   px[c*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  // one pixel request, held until taken
  task automatic send_pixel(logic sof, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    px_result_t  exp_px;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    start_of_image_i <= sof;
    red_i            <= r;
    green_i          <= g;
    blue_i           <= b;
    do @(posedge clk_i); while (in_stall_o);
    exp_px = segment_pixel(sof, r, g, b);
    pixel_results_q = {pixel_results_q, exp_px};
  endtask

  task automatic send_row(row_kind_e kind, int unsigned n, logic sof);
    logic [23:0] px;
    for (int unsigned i = 0; i < n; i++) begin
      px = make_pixel(kind);
      send_pixel(sof && i == 0, px[23:16], px[15:8], px[7:0]);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixel_results_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [WidthW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH:  img_width  = data;
      CFG_HEIGHT: img_height = data;
      CFG_THRESH: ink_thresh = data[7:0];
      CFG_GAP:    gap_limit  = data[3:0];
      default:    ;
    endcase
  endtask

  task automatic configure(logic [WidthW-1:0] w, logic [WidthW-1:0] h,
                           logic [WidthW-1:0] thresh, logic [WidthW-1:0] gap);
    wait_drained();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_THRESH, thresh);
    write_reg(CFG_GAP, gap);
  endtask

  task automatic test_grey_extremes();
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'hFF, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h00, 8'hFF);
    send_pixel(1'b0, 8'hAA, 8'h55, 8'h0F);
  endtask

  // width zero clamps to one pixel per row
  task automatic test_single_pixel_rows();
    configure(13'd0, 13'd8, 13'd0, 13'd0);
    send_row(ROW_INK, 1, 1'b1);
    send_row(ROW_BLANK, 1, 1'b0);
    send_row(ROW_INK, 2, 1'b0);
    send_row(ROW_BLANK, 1, 1'b0);
  endtask

  // line with tolerated gaps, then a short line dropped with a stale gap count
  task automatic test_gap_tolerance();
    configure(13'd1, 13'd12, 13'd100, 13'd2);
    send_row(ROW_INK, 1, 1'b1);
    send_row(ROW_BLANK, 2, 1'b0);
    send_row(ROW_INK, 1, 1'b0);
    send_row(ROW_BLANK, 3, 1'b0);
    send_row(ROW_INK, 1, 1'b0);
    send_row(ROW_BLANK, 1, 1'b0);
  endtask

  task automatic test_height_limit();
    configure(13'd2, 13'd2, 13'd255, 13'd15);
    send_row(ROW_INK, 6, 1'b1);
    configure(13'd32, 13'd0, 13'd0, 13'd0);
    send_row(ROW_NOISE, 2, 1'b1);
  endtask

  task automatic test_random_images();
    int unsigned sent_px;
    int unsigned eff_w;
    int unsigned rows;
    int unsigned n;
    int unsigned pick;
    logic [WidthW-1:0] w;
    logic [WidthW-1:0] h;
    logic [WidthW-1:0] thresh;
    logic [WidthW-1:0] gap;
    logic sof;
    row_kind_e kind;
    sent_px = 0;
    while (sent_px < RandomPixels) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      w = WidthW'($urandom_range(1, 8));
      else if (pick < 85) w = WidthW'($urandom_range(32, 48));
      else if (pick < 95) w = WidthW'($urandom_range(0, 2));
      else                w = WidthW'($urandom_range(9, 120));
      pick = $urandom_range(0, 99);
      if (pick < 60)      h = WidthW'($urandom_range(4, 24));
      else if (pick < 80) h = WidthW'($urandom_range(1, 3));
      else if (pick < 88) h = '0;
      else                h = WidthW'($urandom_range(25, 8191));
      thresh = WidthW'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 120)
                                                   : $urandom_range(0, 255));
      thresh[WidthW-1:8] = (WidthW-8)'($urandom_range(0, 31));
      gap = WidthW'(($urandom_range(0, 511) << 4) | $urandom_range(0, 15));
      configure(w, h, thresh, gap);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      eff_w = (w == '0) ? 1 : 32'(w);
      rows = ((h > 24) ? 24 : 32'(h)) + $urandom_range(0, 2);
      while (eff_w * rows > 300 && rows > 1) rows--;
      repeat ($urandom_range(1, 2)) begin
        kind = row_kind_e'($urandom_range(0, 3));
        for (int unsigned i = 0; i < rows; i++) begin
          if ($urandom_range(0, 9) < 4) kind = row_kind_e'($urandom_range(0, 3));
          n    = eff_w;
          sof  = (i == 0);
          pick = $urandom_range(0, 99);
          // broken sequences: cut rows, restarts mid-image, missing start
          if (pick < 4)      n = $urandom_range(1, eff_w);
          else if (pick < 7) sof = 1'b1;
          else if (pick < 9) sof = 1'b0;
          send_row(kind, n, sof);
          sent_px += n;
          if ($urandom_range(0, 29) == 0) wait_drained();
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // widths at and above the maximum keep the row open
  task automatic test_wide_rows();
    configure(13'd8191, 13'd1, 13'd254, 13'd0);
    send_row(ROW_INK, WidePixels, 1'b1);
    configure(13'd4096, 13'd2, 13'd0, 13'd0);
    send_row(ROW_NOISE, WidePixels, 1'b1);
  endtask

  // line count saturates at 255
  task automatic test_line_count_saturation();
    configure(13'd1, 13'd8191, 13'd0, 13'd0);
    send_row(ROW_BLANK, 1, 1'b1);
    repeat (260) begin
      send_row(ROW_INK, 1, 1'b0);
      send_row(ROW_BLANK, 1, 1'b0);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_results_q.size() == 0) begin
        mismatches++;
        $error("result with no pixel pending");
      end else begin
        want_px = pixel_results_q.pop_front();
        check_field("grey", want_px.grey, grey_o);
        check_field("row_done", want_px.row_done, row_done_o);
        check_field("row_value", want_px.row_value, row_value_o);
        check_field("line_found", want_px.line_found, line_found_o);
        check_field("line_top", want_px.line_top, line_top_o);
        check_field("line_bottom", want_px.line_bottom, line_bottom_o);
        check_field("line_index", want_px.line_index, line_index_o);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      stall_left  = pick_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_WIDTH;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    start_of_image_i = 1'b0;
    red_i            = '0;
    green_i          = '0;
    blue_i           = '0;
    out_stall_i      = 1'b0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    mismatches       = 0;
    cycles           = 0;
    stall_left       = 0;
    img_width        = 13'd640;
    img_height       = 13'd480;
    ink_thresh       = 8'd8;
    gap_limit        = 4'd3;
    clear_detector();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_grey_extremes();
    test_single_pixel_rows();
    test_gap_tolerance();
    test_height_limit();
    test_random_images();
    test_wide_rows();
    test_line_count_saturation();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pixel_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
